@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define TSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TSS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tssat_pkg.sv @@
// Shared types, codes and the gate-to-edge table of the 2-SAT solver.
`timescale 1ns / 1ps
package tssat_pkg;

  localparam int VW  = 10;  // variable index width
  localparam int EDW = 22;  // stored edge word: {sv, sh, dv, dh}
  localparam int NVW_CFG = 11;

  localparam logic [1:0] GATE_AND = 2'd0;
  localparam logic [1:0] GATE_OR  = 2'd1;
  localparam logic [1:0] GATE_XOR = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OVF   = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  localparam logic REG_NUM_VARS = 1'b0;  // paddr[2] of the num_vars register

  typedef enum logic [28:0] {
    ST_IDLE     = 29'h1 << 0,
    ST_DISP     = 29'h1 << 1,
    ST_ADD      = 29'h1 << 2,
    ST_SCLR     = 29'h1 << 3,
    ST_CNT_RD   = 29'h1 << 4,
    ST_CNT_CHK  = 29'h1 << 5,
    ST_CNT_WR   = 29'h1 << 6,
    ST_PFX_RD   = 29'h1 << 7,
    ST_PFX_WR   = 29'h1 << 8,
    ST_SC_RD    = 29'h1 << 9,
    ST_SC_CHK   = 29'h1 << 10,
    ST_SC_WR    = 29'h1 << 11,
    ST_ROOT     = 29'h1 << 12,
    ST_ROOT_CHK = 29'h1 << 13,
    ST_V1       = 29'h1 << 14,
    ST_V2       = 29'h1 << 15,
    ST_V3       = 29'h1 << 16,
    ST_STEP     = 29'h1 << 17,
    ST_ADJ      = 29'h1 << 18,
    ST_WCHK     = 29'h1 << 19,
    ST_POP      = 29'h1 << 20,
    ST_CS_RD    = 29'h1 << 21,
    ST_CS       = 29'h1 << 22,
    ST_UP       = 29'h1 << 23,
    ST_PAR      = 29'h1 << 24,
    ST_CHK_RD1  = 29'h1 << 25,
    ST_CHK_RD2  = 29'h1 << 26,
    ST_CHK_CMP  = 29'h1 << 27,
    ST_DONE     = 29'h1 << 28
  } st_t;

  typedef struct packed {
    st_t  st;
    logic load;      // latch the input item
    logic nidx_clr;  // restart node sweep
    logic eidx_clr;  // restart edge sweep
  } cmd_t;

  typedef struct packed {
    logic act;
    logic err_any;
    logic add_done;
    logic sclr_done;
    logic e_done;
    logic e_bad;
    logic pfx_done;
    logic root_done;
    logic vis_zero;
    logic has_edge;
    logic root_comp;
    logic cs_more;
    logic has_parent;
    logic chk_done;
    logic comp_eq;
    logic out_busy;
  } sts_t;

  // Edge j of a gate constraint; literal h=1 is the "variable is one" node.
  function automatic logic [EDW-1:0] edge_word(input logic [VW-1:0] x,
                                               input logic [VW-1:0] y,
                                               input logic c,
                                               input logic [1:0] g,
                                               input logic [1:0] j);
    logic [VW:0] x0, x1, y0, y1, s, d;
    x0 = {x, 1'b0};
    x1 = {x, 1'b1};
    y0 = {y, 1'b0};
    y1 = {y, 1'b1};
    s  = x0;
    d  = x1;
    unique case (g)
      GATE_AND: begin
        if (c) begin
          s = j[0] ? y0 : x0;  d = j[0] ? y1 : x1;
        end else begin
          s = j[0] ? y1 : x1;  d = j[0] ? x0 : y0;
        end
      end
      GATE_OR: begin
        if (c) begin
          s = j[0] ? y0 : x0;  d = j[0] ? x1 : y1;
        end else begin
          s = j[0] ? y1 : x1;  d = j[0] ? y0 : x0;
        end
      end
      GATE_XOR: begin
        if (c) begin
          unique case (j)
            2'd0:    begin s = x0; d = y1; end
            2'd1:    begin s = x1; d = y0; end
            2'd2:    begin s = y0; d = x1; end
            default: begin s = y1; d = x0; end
          endcase
        end else begin
          unique case (j)
            2'd0:    begin s = x0; d = y0; end
            2'd1:    begin s = y0; d = x0; end
            2'd2:    begin s = x1; d = y1; end
            default: begin s = y1; d = x1; end
          endcase
        end
      end
      default: begin
        s = x0;  d = x1;
      end
    endcase
    return {s, d};
  endfunction

endpackage

@@ sv/tssat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tssat_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/tssat_ctrl.sv @@
// Sequencer of the solver: add, clear, build adjacency, Tarjan walk, check.
`timescale 1ns / 1ps
module tssat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tssat_pkg::sts_t sts,
  output tssat_pkg::cmd_t cmd
);
  import tssat_pkg::*;

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.st       = state;
    cmd.load     = 1'b0;
    cmd.nidx_clr = 1'b0;
    cmd.eidx_clr = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.act == ACT_ADD) begin
          state_next = ST_ADD;
        end else if (sts.err_any) begin
          state_next = ST_DONE;
        end else begin
          cmd.nidx_clr = 1'b1;
          state_next   = ST_SCLR;
        end
      end
      ST_ADD:     if (sts.add_done) state_next = ST_IDLE;
      ST_SCLR: begin
        if (sts.sclr_done) begin
          cmd.eidx_clr = 1'b1;
          state_next   = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        if (sts.e_done) begin
          cmd.nidx_clr = 1'b1;
          state_next   = ST_PFX_RD;
        end else begin
          state_next = ST_CNT_CHK;
        end
      end
      ST_CNT_CHK: state_next = sts.e_bad ? ST_DONE : ST_CNT_WR;
      ST_CNT_WR:  state_next = ST_CNT_RD;
      ST_PFX_RD: begin
        if (sts.pfx_done) begin
          cmd.eidx_clr = 1'b1;
          state_next   = ST_SC_RD;
        end else begin
          state_next = ST_PFX_WR;
        end
      end
      ST_PFX_WR:  state_next = ST_PFX_RD;
      ST_SC_RD: begin
        if (sts.e_done) begin
          cmd.nidx_clr = 1'b1;
          state_next   = ST_ROOT;
        end else begin
          state_next = ST_SC_CHK;
        end
      end
      ST_SC_CHK:  state_next = ST_SC_WR;
      ST_SC_WR:   state_next = ST_SC_RD;
      ST_ROOT: begin
        if (sts.root_done) begin
          cmd.nidx_clr = 1'b1;
          state_next   = ST_CHK_RD1;
        end else begin
          state_next = ST_ROOT_CHK;
        end
      end
      ST_ROOT_CHK: state_next = sts.vis_zero ? ST_V1 : ST_ROOT;
      ST_V1:       state_next = ST_V2;
      ST_V2:       state_next = ST_V3;
      ST_V3:       state_next = ST_STEP;
      ST_STEP:     state_next = sts.has_edge ? ST_ADJ : ST_POP;
      ST_ADJ:      state_next = ST_WCHK;
      ST_WCHK:     state_next = sts.vis_zero ? ST_V1 : ST_STEP;
      ST_POP:      state_next = sts.root_comp ? ST_CS_RD : ST_UP;
      ST_CS_RD:    state_next = ST_CS;
      ST_CS:       state_next = sts.cs_more ? ST_CS_RD : ST_UP;
      ST_UP:       state_next = sts.has_parent ? ST_PAR : ST_ROOT;
      ST_PAR:      state_next = ST_STEP;
      ST_CHK_RD1:  state_next = sts.chk_done ? ST_DONE : ST_CHK_RD2;
      ST_CHK_RD2:  state_next = ST_CHK_CMP;
      ST_CHK_CMP:  state_next = sts.comp_eq ? ST_DONE : ST_CHK_RD1;
      ST_DONE:     if (!sts.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end
endmodule

@@ sv/tssat_dp.sv @@
// Datapath: config register, edge store, working memories, Tarjan frame, result.
`timescale 1ns / 1ps
module tssat_dp #(
  parameter int MAX_VARS  = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tssat_pkg::cmd_t              cmd,
  output tssat_pkg::sts_t              sts,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  input  logic                         action,
  input  logic [tssat_pkg::VW-1:0]     var_a,
  input  logic [tssat_pkg::VW-1:0]     var_b,
  input  logic                         wanted,
  input  logic [1:0]                   gate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         satisfiable,
  output logic [1:0]                   error
);
  import tssat_pkg::*;

  localparam int NODES = 2 * MAX_VARS;
  localparam int NVW   = $clog2(MAX_VARS + 1);
  localparam int NCW   = $clog2(NODES + 1);
  localparam int NAW   = $clog2(NODES);
  localparam int EW    = $clog2(MAX_EDGES + 1);
  localparam int EAW   = $clog2(MAX_EDGES);
  localparam int FW    = NAW + 2 * EW + 2 * NCW;

  logic [NVW_CFG-1:0] num_vars;
  logic [NVW-1:0]     n;
  logic [NCW-1:0]     nodes;

  logic           it_action, it_c;
  logic [VW-1:0]  it_a, it_b;
  logic [1:0]     it_g, add_j;
  logic [EW-1:0]  edge_count, eidx, sum;
  logic [1:0]     err;
  logic [NCW-1:0] nidx, counter, parts, csp, fsp;
  logic [NAW-1:0] cur_v, w_r, e_dst;
  logic [NCW-1:0] e_src;
  logic [EW-1:0]  cur_pos, cur_end;
  logic [NCW-1:0] cur_low, cur_vis, cmp_a;
  logic           sat;

  // RAM ports
  logic           ed_we;
  logic [EAW-1:0] ed_waddr, ed_raddr;
  logic [EDW-1:0] ed_wdata, ed_rdata;
  logic           of_we;
  logic [NCW-1:0] of_waddr, of_raddr;
  logic [EW-1:0]  of_wdata, of_rdata;
  logic           aj_we;
  logic [EAW-1:0] aj_waddr, aj_raddr;
  logic [NAW-1:0] aj_wdata, aj_rdata;
  logic           cu_we;
  logic [NAW-1:0] cu_waddr, cu_raddr;
  logic [EW-1:0]  cu_wdata, cu_rdata;
  logic           vi_we;
  logic [NAW-1:0] vi_waddr, vi_raddr;
  logic [NCW-1:0] vi_wdata, vi_rdata;
  logic           os_we;
  logic [NAW-1:0] os_waddr, os_raddr;
  logic           os_wdata, os_rdata;
  logic           cm_we;
  logic [NAW-1:0] cm_waddr, cm_raddr;
  logic [NCW-1:0] cm_wdata, cm_rdata;
  logic           ck_we;
  logic [NAW-1:0] ck_waddr, ck_raddr;
  logic [NAW-1:0] ck_wdata, ck_rdata;
  logic           cl_we;
  logic [NAW-1:0] cl_waddr, cl_raddr;
  logic [FW-1:0]  cl_wdata, cl_rdata;

  logic           cfg_wr, add_bad, add_ovf, add_wr;
  logic [2:0]     add_k;
  logic [VW-1:0]  e_sv, e_dv;
  logic           e_sh, e_dh;
  logic [NCW-1:0] src_node, dst_node, src_p1, csp_m1, fsp_m1, fsp_m2, chk_hi, pfx_end;
  logic [EW-1:0]  pfx_sum;
  logic [NAW-1:0] fr_v;
  logic [EW-1:0]  fr_pos, fr_end;
  logic [NCW-1:0] fr_low, fr_vis;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_VARS);
  assign prdata = (paddr[2] == REG_NUM_VARS) ? {21'b0, num_vars} : 32'b0;

  assign n     = ({21'b0, num_vars} > 32'(MAX_VARS)) ? NVW'(MAX_VARS) : NVW'(num_vars);
  assign nodes = NCW'({n, 1'b0});

  assign add_k   = (it_g == GATE_XOR) ? 3'd4 :
                   ((it_g == GATE_AND) || (it_g == GATE_OR)) ? 3'd2 : 3'd0;
  assign add_bad = (it_a >= n) || (it_b >= n);
  assign add_ovf = (add_j == 2'd0) &&
                   ({1'b0, edge_count} + (EW + 1)'(add_k) > (EW + 1)'(MAX_EDGES));
  assign add_wr  = !add_bad && (add_k != 3'd0) && !add_ovf;

  assign e_sv     = ed_rdata[EDW-1 -: VW];
  assign e_sh     = ed_rdata[VW + 1];
  assign e_dv     = ed_rdata[VW:1];
  assign e_dh     = ed_rdata[0];
  assign src_node = NCW'(e_sv) + (e_sh ? NCW'(n) : NCW'(0));
  assign dst_node = NCW'(e_dv) + (e_dh ? NCW'(n) : NCW'(0));
  assign src_p1   = e_src + NCW'(1);
  assign csp_m1   = csp - NCW'(1);
  assign fsp_m1   = fsp - NCW'(1);
  assign fsp_m2   = fsp - NCW'(2);
  assign chk_hi   = nidx + NCW'(n);
  assign pfx_end  = nodes + NCW'(1);
  assign pfx_sum  = sum + of_rdata;

  assign {fr_v, fr_pos, fr_end, fr_low, fr_vis} = cl_rdata;

  always_comb begin
    ed_we = 1'b0;  ed_waddr = edge_count[EAW-1:0];
    ed_wdata = edge_word(it_a, it_b, it_c, it_g, add_j);
    ed_raddr = eidx[EAW-1:0];
    of_we = 1'b0;  of_waddr = nidx;  of_wdata = '0;  of_raddr = nidx;
    aj_we = 1'b0;  aj_waddr = cu_rdata[EAW-1:0];  aj_wdata = e_dst;
    aj_raddr = cur_pos[EAW-1:0];
    cu_we = 1'b0;  cu_waddr = nidx[NAW-1:0];  cu_wdata = pfx_sum;
    cu_raddr = src_node[NAW-1:0];
    vi_we = 1'b0;  vi_waddr = nidx[NAW-1:0];  vi_wdata = '0;
    vi_raddr = nidx[NAW-1:0];
    os_we = 1'b0;  os_waddr = nidx[NAW-1:0];  os_wdata = 1'b0;
    os_raddr = aj_rdata;
    cm_we = 1'b0;  cm_waddr = ck_rdata;  cm_wdata = parts;
    cm_raddr = nidx[NAW-1:0];
    ck_we = 1'b0;  ck_waddr = csp[NAW-1:0];  ck_wdata = w_r;
    ck_raddr = csp_m1[NAW-1:0];
    cl_we = 1'b0;  cl_waddr = fsp_m1[NAW-1:0];
    cl_wdata = {cur_v, cur_pos, cur_end, cur_low, cur_vis};
    cl_raddr = fsp_m2[NAW-1:0];
    unique case (cmd.st)
      ST_ADD:    ed_we = add_wr;
      ST_SCLR: begin
        of_we = 1'b1;
        vi_we = 1'b1;
        os_we = 1'b1;
      end
      ST_CNT_CHK: of_raddr = src_node + NCW'(1);
      ST_CNT_WR: begin
        of_we    = 1'b1;
        of_waddr = src_p1;
        of_wdata = of_rdata + EW'(1);
      end
      ST_PFX_WR: begin
        of_we    = 1'b1;
        of_wdata = pfx_sum;
        cu_we    = (nidx < nodes);
      end
      ST_SC_WR: begin
        aj_we    = 1'b1;
        cu_we    = 1'b1;
        cu_waddr = e_src[NAW-1:0];
        cu_wdata = cu_rdata + EW'(1);
      end
      ST_V1: begin
        vi_we    = 1'b1;
        vi_waddr = w_r;
        vi_wdata = counter + NCW'(1);
        os_we    = 1'b1;
        os_waddr = w_r;
        os_wdata = 1'b1;
        ck_we    = 1'b1;
        cl_we    = (fsp != '0);
        of_raddr = NCW'(w_r);
      end
      ST_V2:     of_raddr = NCW'(w_r) + NCW'(1);
      ST_ADJ:    vi_raddr = aj_rdata;
      ST_CS: begin
        os_we    = 1'b1;
        os_waddr = ck_rdata;
        cm_we    = 1'b1;
      end
      ST_CHK_RD2: cm_raddr = chk_hi[NAW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars   <= NVW_CFG'(1);
      edge_count <= '0;
      err        <= ERR_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        num_vars <= pwdata[NVW_CFG-1:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        it_action <= action;
        it_a      <= var_a;
        it_b      <= var_b;
        it_c      <= wanted;
        it_g      <= gate;
        add_j     <= 2'd0;
        sat       <= 1'b0;
      end
      unique case (cmd.st)
        ST_ADD: begin
          if (add_wr) begin
            edge_count <= edge_count + EW'(1);
            add_j      <= add_j + 2'd1;
          end else if (add_bad) begin
            if (err == ERR_NONE) err <= ERR_RANGE;
          end else if (add_ovf) begin
            if (err == ERR_NONE) err <= ERR_OVF;
          end
        end
        ST_SCLR: begin
          nidx    <= nidx + NCW'(1);
          counter <= '0;
          parts   <= '0;
          csp     <= '0;
          fsp     <= '0;
        end
        ST_CNT_CHK: begin
          if (sts.e_bad) begin
            err <= ERR_RANGE;
          end else begin
            e_src <= src_node;
          end
        end
        ST_CNT_WR:  eidx <= eidx + EW'(1);
        ST_PFX_WR: begin
          sum  <= pfx_sum;
          nidx <= nidx + NCW'(1);
        end
        ST_SC_CHK: begin
          e_src <= src_node;
          e_dst <= dst_node[NAW-1:0];
        end
        ST_SC_WR:   eidx <= eidx + EW'(1);
        ST_ROOT:    if (sts.root_done) sat <= 1'b1;
        ST_ROOT_CHK: begin
          if (vi_rdata != '0) begin
            nidx <= nidx + NCW'(1);
          end else begin
            w_r <= nidx[NAW-1:0];
          end
        end
        ST_V1: begin
          counter <= counter + NCW'(1);
          csp     <= csp + NCW'(1);
        end
        ST_V2:      cur_pos <= of_rdata;
        ST_V3: begin
          cur_end <= of_rdata;
          cur_v   <= w_r;
          cur_low <= counter;
          cur_vis <= counter;
          fsp     <= fsp + NCW'(1);
        end
        ST_STEP:    if (sts.has_edge) cur_pos <= cur_pos + EW'(1);
        ST_ADJ:     w_r <= aj_rdata;
        ST_WCHK: begin
          if ((vi_rdata != '0) && os_rdata && (vi_rdata < cur_low)) begin
            cur_low <= vi_rdata;
          end
        end
        ST_POP:     if (sts.root_comp) parts <= parts + NCW'(1);
        ST_CS:      csp <= csp_m1;
        ST_UP:      fsp <= fsp_m1;
        ST_PAR: begin
          cur_v   <= fr_v;
          cur_pos <= fr_pos;
          cur_end <= fr_end;
          cur_vis <= fr_vis;
          cur_low <= (cur_low < fr_low) ? cur_low : fr_low;
        end
        ST_CHK_RD2: cmp_a <= cm_rdata;
        ST_CHK_CMP: begin
          if (sts.comp_eq) begin
            sat <= 1'b0;
          end else begin
            nidx <= nidx + NCW'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            satisfiable <= sat;
            error       <= err;
            edge_count  <= '0;
            err         <= ERR_NONE;
          end
        end
        default: ;
      endcase
      if (cmd.nidx_clr) begin
        nidx <= '0;
        sum  <= '0;
      end
      if (cmd.eidx_clr) begin
        eidx <= '0;
      end
    end
  end

  always_comb begin
    sts.act        = it_action;
    sts.err_any    = (err != ERR_NONE);
    sts.add_done   = add_bad || (add_k == 3'd0) || add_ovf || ({1'b0, add_j} == add_k - 3'd1);
    sts.sclr_done  = (nidx == nodes);
    sts.e_done     = (eidx == edge_count);
    sts.e_bad      = (e_sv >= n) || (e_dv >= n);
    sts.pfx_done   = (nidx == pfx_end);
    sts.root_done  = (nidx == nodes);
    sts.vis_zero   = (vi_rdata == '0);
    sts.has_edge   = (cur_pos < cur_end);
    sts.root_comp  = (cur_low == cur_vis);
    sts.cs_more    = (ck_rdata != cur_v) && (csp > NCW'(1));
    sts.has_parent = (fsp > NCW'(1));
    sts.chk_done   = (nidx == NCW'(n));
    sts.comp_eq    = (cm_rdata == cmp_a);
    sts.out_busy   = out_valid;
  end

  tssat_ram #(.W(EDW), .D(MAX_EDGES)) u_edge (
    .clk, .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata), .raddr(ed_raddr), .rdata(ed_rdata));
  tssat_ram #(.W(EW), .D(NODES + 1)) u_offs (
    .clk, .we(of_we), .waddr(of_waddr), .wdata(of_wdata), .raddr(of_raddr), .rdata(of_rdata));
  tssat_ram #(.W(NAW), .D(MAX_EDGES)) u_adj (
    .clk, .we(aj_we), .waddr(aj_waddr), .wdata(aj_wdata), .raddr(aj_raddr), .rdata(aj_rdata));
  tssat_ram #(.W(EW), .D(NODES)) u_cursor (
    .clk, .we(cu_we), .waddr(cu_waddr), .wdata(cu_wdata), .raddr(cu_raddr), .rdata(cu_rdata));
  tssat_ram #(.W(NCW), .D(NODES)) u_visit (
    .clk, .we(vi_we), .waddr(vi_waddr), .wdata(vi_wdata), .raddr(vi_raddr), .rdata(vi_rdata));
  tssat_ram #(.W(1), .D(NODES)) u_onstk (
    .clk, .we(os_we), .waddr(os_waddr), .wdata(os_wdata), .raddr(os_raddr), .rdata(os_rdata));
  tssat_ram #(.W(NCW), .D(NODES)) u_comp (
    .clk, .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata), .raddr(cm_raddr), .rdata(cm_rdata));
  tssat_ram #(.W(NAW), .D(NODES)) u_cstk (
    .clk, .we(ck_we), .waddr(ck_waddr), .wdata(ck_wdata), .raddr(ck_raddr), .rdata(ck_rdata));
  tssat_ram #(.W(FW), .D(NODES)) u_call (
    .clk, .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata), .raddr(cl_raddr), .rdata(cl_rdata));
endmodule

@@ sv/two_sat_scc_solver_core.sv @@
// 2-SAT solver for gate constraints: strongly connected components on edge memories.
// Input channel (in_valid/in_ready): action 0 adds one AND/OR/XOR constraint,
// action 1 solves the stored set and clears it. Only a solve gives a result on
// the output channel (out_valid/out_ready): satisfiable and error.
// num_vars is written over the APB port at address 0; the user must write it
// only while the block is idle, as the block itself does not enforce it. An
// add keeps the input busy after its transfer: a dispatch state, then the add
// state, which writes each edge of the constraint into the edge store in turn
// (or ends at once when none is written); no new item is taken until the add ends.
// A solve runs through: a clear sweep over offsets/visit/on-stack, an offset
// count over the edges, a prefix sweep over the nodes, an adjacency scatter
// over the edges, the Tarjan walk over nodes and edges, and the final
// component compare over the variables. A solve with an error already latched
// goes from dispatch straight to the result. The result sits in an output
// register; while it is not taken, adds are still accepted, and a finished
// solve waits until the register frees up.
// Reset (rst, synchronous) empties the store, clears errors, sets num_vars to 1.
`timescale 1ns / 1ps
module two_sat_scc_solver_core #(
  parameter int MAX_VARS  = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [tssat_pkg::VW-1:0] var_a,
  input  logic [tssat_pkg::VW-1:0] var_b,
  input  logic                     wanted,
  input  logic [1:0]               gate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     satisfiable,
  output logic [1:0]               error
);
  import tssat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  tssat_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .sts, .cmd
  );

  tssat_dp #(.MAX_VARS(MAX_VARS), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .cmd, .sts,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .action, .var_a, .var_b, .wanted, .gate,
    .out_valid, .out_ready, .satisfiable, .error
  );
endmodule

@@ sv/tssat_checker.sv @@
// Port-level checks of the solver, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tssat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        satisfiable,
  input logic [1:0]  error
);
  import tssat_pkg::*;

  `TSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(satisfiable) && $stable(error), "result changed while stalled")
  `TSS_ASSERT(a_err_unsat, out_valid && (error != ERR_NONE) |-> !satisfiable, "error reported as satisfiable")
  `TSS_ASSERT(a_err_code, out_valid |-> (error == ERR_NONE || error == ERR_OVF || error == ERR_RANGE), "bad error code")
  `TSS_ASSERT_RST(a_rst_clear, rst |=> !out_valid && in_ready, "reset left a result or busy state")
endmodule

bind two_sat_scc_solver_core tssat_checker u_tssat_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .satisfiable, .error
);
